>>> hw/rtl/psc_pkg.sv
package psc_pkg;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_GAIN_P       = 3'd0;
    localparam cfg_index_t CFG_GAIN_I       = 3'd1;
    localparam cfg_index_t CFG_GAIN_D       = 3'd2;
    localparam cfg_index_t CFG_OUTPUT_MAX   = 3'd3;
    localparam cfg_index_t CFG_OUTPUT_MIN   = 3'd4;
    localparam cfg_index_t CFG_WINDUP_LIMIT = 3'd5;

    typedef struct packed {
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic signed [15:0] output_max;
        logic signed [15:0] output_min;
        logic [14:0]        windup_limit;
    } psc_cfg_t;

    localparam logic [15:0]        RESET_GAIN_P       = 16'd41;
    localparam logic [15:0]        RESET_GAIN_I       = 16'd410;
    localparam logic [15:0]        RESET_GAIN_D       = 16'd3072;
    localparam logic signed [15:0] RESET_OUTPUT_MAX   = 16'sd2304;
    localparam logic signed [15:0] RESET_OUTPUT_MIN   = -16'sd2304;
    localparam logic [14:0]        RESET_WINDUP_LIMIT = 15'd1280;

endpackage

>>> hw/rtl/psc_cfg_regs.sv
module psc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  psc_pkg::cfg_index_t cfg_index,
    input  logic [15:0]         cfg_data,
    output psc_pkg::psc_cfg_t   cfg
);
    import psc_pkg::*;

    psc_cfg_t cfg_reg;
    psc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:       cfg_next.gain_p       = cfg_data;
                CFG_GAIN_I:       cfg_next.gain_i       = cfg_data;
                CFG_GAIN_D:       cfg_next.gain_d       = cfg_data;
                CFG_OUTPUT_MAX:   cfg_next.output_max   = $signed(cfg_data);
                CFG_OUTPUT_MIN:   cfg_next.output_min   = $signed(cfg_data);
                CFG_WINDUP_LIMIT: cfg_next.windup_limit = cfg_data[14:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= RESET_GAIN_P;
            cfg_reg.gain_i       <= RESET_GAIN_I;
            cfg_reg.gain_d       <= RESET_GAIN_D;
            cfg_reg.output_max   <= RESET_OUTPUT_MAX;
            cfg_reg.output_min   <= RESET_OUTPUT_MIN;
            cfg_reg.windup_limit <= RESET_WINDUP_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/psc_datapath.sv
module psc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  psc_pkg::psc_cfg_t  cfg,
    input  logic signed [15:0] target_speed,
    input  logic signed [15:0] measured_speed,
    output logic signed [15:0] drive_next,
    output logic               clamped_next
);
    import psc_pkg::*;

    logic signed [16:0] last_error_reg;
    logic signed [31:0] error_sum_reg;
    logic signed [15:0] last_drive_reg;

    logic signed [16:0] err;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_next;
    logic signed [17:0] diff;
    logic signed [33:0] p_prod;
    logic signed [48:0] i_prod;
    logic signed [34:0] d_prod;
    logic signed [50:0] p_ext;
    logic signed [50:0] i_ext;
    logic signed [50:0] d_ext;
    logic signed [50:0] acc;
    logic signed [50:0] rounded;
    logic signed [38:0] value;
    logic signed [38:0] max_ext;
    logic signed [38:0] min_ext;
    logic signed [38:0] after_max;
    logic signed [38:0] after_min;
    logic signed [16:0] last_drive_ext;
    logic [16:0]        last_mag;
    logic               use_integral;
    logic               clip_max;
    logic               clip_min;

    always_comb
    begin
        err      = $signed({target_speed[15], target_speed})
                 - $signed({measured_speed[15], measured_speed});
        sum_wide = $signed({error_sum_reg[31], error_sum_reg})
                 + $signed({{16{err[16]}}, err});
        if (sum_wide[32] != sum_wide[31])
        begin
            sum_next = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[31:0];
        end

        diff = $signed({err[16], err}) - $signed({last_error_reg[16], last_error_reg});

        p_prod = $signed({1'b0, cfg.gain_p}) * err;
        i_prod = $signed({1'b0, cfg.gain_i}) * sum_next;
        d_prod = $signed({1'b0, cfg.gain_d}) * diff;

        // The integral term is dropped when the previous drive was beyond the limit.
        last_drive_ext = $signed({last_drive_reg[15], last_drive_reg});
        last_mag       = last_drive_reg[15] ? (17'd0 - last_drive_ext) : last_drive_ext;
        use_integral   = (last_mag <= {2'b00, cfg.windup_limit});

        p_ext = $signed({{17{p_prod[33]}}, p_prod});
        i_ext = use_integral ? $signed({{2{i_prod[48]}}, i_prod}) : '0;
        d_ext = $signed({{16{d_prod[34]}}, d_prod});
        acc   = p_ext + i_ext + d_ext;

        // Round to nearest with ties toward plus infinity.
        rounded = acc + 51'sd2048;
        value   = rounded[50:12];

        max_ext   = $signed({{23{cfg.output_max[15]}}, cfg.output_max});
        min_ext   = $signed({{23{cfg.output_min[15]}}, cfg.output_min});
        clip_max  = (value > max_ext);
        after_max = clip_max ? max_ext : value;
        clip_min  = (after_max < min_ext);
        after_min = clip_min ? min_ext : after_max;

        drive_next   = after_min[15:0];
        clamped_next = clip_max | clip_min;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            last_drive_reg <= '0;
        end
        else if (step)
        begin
            last_error_reg <= err;
            error_sum_reg  <= sum_next;
            last_drive_reg <= drive_next;
        end
    end

endmodule

>>> hw/rtl/pid_speed_controller_unit.sv
// Positional PID speed controller with conditional integration. Each input
// transaction carries a target and a measured speed in signed Q8.8 and yields
// exactly one output transaction with the clamped drive and a clamp flag. The
// block accepts one transaction per cycle while the output is not stalled;
// each is held in the input register, then the combinational datapath updates
// the error sum, the last error and the last drive before the next item is
// processed and feeds the output register. Gains and limits come from six
// configuration registers, which are always ready and should be written only
// while no transaction is in flight; an unknown register index is ignored.
module pid_speed_controller_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  target_speed,
    input  logic signed [15:0]  measured_speed,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  drive,
    output logic                clamped,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  psc_pkg::cfg_index_t cfg_index,
    input  logic [15:0]         cfg_data
);
    import psc_pkg::*;

    psc_cfg_t cfg;

    logic               in_valid_reg;
    logic signed [15:0] target_reg;
    logic signed [15:0] measured_reg;
    logic               out_valid_reg;
    logic signed [15:0] drive_reg;
    logic               clamped_reg;
    logic               step;
    logic signed [15:0] drive_next;
    logic               clamped_next;

    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step;

    psc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cfg            (cfg),
        .target_speed   (target_reg),
        .measured_speed (measured_reg),
        .drive_next     (drive_next),
        .clamped_next   (clamped_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            target_reg   <= target_speed;
            measured_reg <= measured_speed;
        end
        if (step)
        begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

endmodule

>>> hw/rtl/psc_checker.sv
module psc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic signed [15:0]  target_speed,
    input logic signed [15:0]  measured_speed,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [15:0]  drive,
    input logic                clamped,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input psc_pkg::cfg_index_t cfg_index,
    input logic [15:0]         cfg_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
        else $error("output changed while stalled");

    // With the output register empty, the input side can always take a transaction.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // An accepted transaction is checked to reach the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted transaction did not reach the output");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind pid_speed_controller_unit psc_checker u_psc_checker (.*);

>>> bench/pid_speed_controller_unit_test.sv
`timescale 1ns / 1ps

module pid_speed_controller_unit_test;
    import psc_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         PHASE_ITEMS    = 200;
    localparam cfg_index_t CFG_SPARE_LO   = 3'd6;
    localparam cfg_index_t CFG_SPARE_HI   = 3'd7;

    typedef struct {
        logic signed [15:0] drive;
        logic               clamped;
    } drive_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] drive;
    logic               clamped;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_index_t         cfg_index;
    logic [15:0]        cfg_data;

    drive_result_t      drive_expect_q[$];
    int                 failures     = 0;
    int                 idle_pct     = 0;
    int                 stall_pct    = 0;
    int                 quiet_cycles = 0;

    logic [15:0]        kp_m;
    logic [15:0]        ki_m;
    logic [15:0]        kd_m;
    logic signed [15:0] drive_max_m;
    logic signed [15:0] drive_min_m;
    logic [14:0]        windup_m;
    longint             last_err_m;
    int                 err_sum_m;
    logic signed [15:0] last_drive_m;

    pid_speed_controller_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive          (drive),
        .clamped        (clamped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void apply_setting(input cfg_index_t idx, input logic [15:0] data);
        case (idx)
            CFG_GAIN_P:       kp_m = data;
            CFG_GAIN_I:       ki_m = data;
            CFG_GAIN_D:       kd_m = data;
            CFG_OUTPUT_MAX:   drive_max_m = data;
            CFG_OUTPUT_MIN:   drive_min_m = data;
            CFG_WINDUP_LIMIT: windup_m = data[14:0];
            default:          ;
        endcase
    endfunction

    function automatic void predict_drive(input logic signed [15:0] tgt,
                                          input logic signed [15:0] meas);
        longint        err;
        longint        sum_next;
        longint        acc;
        longint        mag;
        longint        value;
        drive_result_t res;
        err = longint'(tgt) - longint'(meas);
        sum_next = longint'(err_sum_m) + err;
        if (sum_next > longint'(32'sh7FFF_FFFF))
            sum_next = longint'(32'sh7FFF_FFFF);
        if (sum_next < -longint'(64'sd2147483648))
            sum_next = -longint'(64'sd2147483648);
        err_sum_m = int'(sum_next);
        acc = longint'(kp_m) * err;
        mag = (last_drive_m < 0) ? -longint'(last_drive_m) : longint'(last_drive_m);
        if (mag <= longint'(windup_m))
            acc = acc + longint'(ki_m) * longint'(err_sum_m);
        acc = acc + longint'(kd_m) * (err - last_err_m);
        last_err_m = err;
        value = (acc + 2048) >>> 12;
        res.clamped = 1'b0;
        if (value > longint'(drive_max_m))
        begin
            value = longint'(drive_max_m);
            res.clamped = 1'b1;
        end
        if (value < longint'(drive_min_m))
        begin
            value = longint'(drive_min_m);
            res.clamped = 1'b1;
        end
        last_drive_m = 16'(value);
        res.drive = last_drive_m;
        drive_expect_q.push_back(res);
    endfunction

    always @(posedge clk)
    begin : result_check
        drive_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected transaction: drive %0d clamped %0b",
                             $time, drive, clamped);
                end
                else
                begin
                    exp_r = drive_expect_q.pop_front();
                    if (drive !== exp_r.drive)
                    begin
                        failures++;
                        $display("%0t: drive mismatch: expected %0d, actual %0d",
                                 $time, exp_r.drive, drive);
                    end
                    if (clamped !== exp_r.clamped)
                    begin
                        failures++;
                        $display("%0t: clamped mismatch: expected %0b, actual %0b",
                                 $time, exp_r.clamped, clamped);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predict_drive(target_speed, measured_speed);
        end
        else
        begin
            kp_m         = RESET_GAIN_P;
            ki_m         = RESET_GAIN_I;
            kd_m         = RESET_GAIN_D;
            drive_max_m  = RESET_OUTPUT_MAX;
            drive_min_m  = RESET_OUTPUT_MIN;
            windup_m     = RESET_WINDUP_LIMIT;
            last_err_m   = 0;
            err_sum_m    = 0;
            last_drive_m = '0;
            drive_expect_q.delete();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic signed [15:0] rand_speed();
        logic signed [15:0] v;
        case ($urandom_range(3))
            0: v = 16'($urandom);
            1: v = 16'(int'($urandom_range(2048)) - 1024);
            2: v = 16'(int'($urandom_range(128)) - 64);
            default:
                case ($urandom_range(3))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sh0000;
                    default: v = 16'shFFFF;
                endcase
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_gain();
        logic [15:0] g;
        case ($urandom_range(3))
            0: g = 16'($urandom);
            1: g = 16'($urandom_range(4096));
            2: g = 16'($urandom_range(256));
            default: g = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        return g;
    endfunction

    task automatic send_speeds(input logic signed [15:0] tgt, input logic signed [15:0] meas);
        logic taken;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        target_speed   <= tgt;
        measured_speed <= meas;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic write_setting(input cfg_index_t idx, input logic [15:0] data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (drive_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pacing(input int idle, input int stall);
        @(negedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        @(posedge clk);
    endtask

    task automatic write_all_settings(input logic [15:0] kp, input logic [15:0] ki,
                                      input logic [15:0] kd, input logic [15:0] hi,
                                      input logic [15:0] lo, input logic [15:0] windup);
        drain_results();
        write_setting(CFG_GAIN_P, kp);
        write_setting(CFG_GAIN_I, ki);
        write_setting(CFG_GAIN_D, kd);
        write_setting(CFG_OUTPUT_MAX, hi);
        write_setting(CFG_OUTPUT_MIN, lo);
        write_setting(CFG_WINDUP_LIMIT, windup);
    endtask

    task automatic randomize_settings();
        logic [15:0] hi;
        logic [15:0] lo;
        case ($urandom_range(3))
            0:
            begin
                hi = 16'h7FFF;
                lo = 16'h8000;
            end
            1:
            begin
                hi = 16'($urandom_range(8192));
                lo = 16'(-int'($urandom_range(8192)));
            end
            2:
            begin
                hi = 16'($urandom);
                lo = 16'($urandom);
            end
            default:
            begin
                hi = 16'($urandom_range(4096));
                lo = 16'(-int'($urandom_range(4096)));
            end
        endcase
        write_all_settings(rand_gain(), rand_gain(), rand_gain(), hi, lo,
                           $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3000)));
    endtask

    task automatic test_reset_values();
        send_speeds(16'sd0, 16'sd0);
        send_speeds(16'sh7FFF, 16'sh8000);
        send_speeds(16'sh8000, 16'sh7FFF);
        send_speeds(16'sh7FFF, 16'sh7FFF);
        send_speeds(16'sh8000, 16'sh8000);
        send_speeds(16'sd256, 16'sd0);
        send_speeds(16'sd256, 16'sd0);
        send_speeds(-16'sd512, 16'sd0);
    endtask

    task automatic test_rounding_ties();
        write_all_settings(16'd2048, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_speeds(16'sd1, 16'sd0);
        send_speeds(16'sd0, 16'sd1);
        send_speeds(16'sd3, 16'sd0);
        send_speeds(-16'sd3, 16'sd0);
    endtask

    task automatic test_windup_threshold();
        write_all_settings(16'd4096, 16'd4096, 16'd0, 16'h7FFF, 16'h8000, 16'h0000);
        send_speeds(16'sd100, 16'sd0);
        send_speeds(16'sd100, 16'sd0);
        send_speeds(16'sd0, 16'sd0);
        write_all_settings(16'hFFFF, 16'd4096, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_speeds(16'sh8000, 16'sh7FFF);
        send_speeds(16'sd0, 16'sd0);
        send_speeds(16'sh7FFF, 16'sh8000);
        send_speeds(16'sd0, 16'sd0);
    endtask

    task automatic test_inverted_limits();
        write_all_settings(16'd4096, 16'd0, 16'd0, 16'hFF9C, 16'd100, 16'd1280);
        send_speeds(16'sd100, 16'sd0);
        send_speeds(16'sh8000, 16'sh7FFF);
        send_speeds(16'sh7FFF, 16'sh8000);
    endtask

    task automatic test_unknown_index();
        drain_results();
        write_setting(CFG_SPARE_LO, 16'hFFFF);
        write_setting(CFG_SPARE_HI, 16'h0000);
        send_speeds(16'sd300, 16'sd0);
        send_speeds(16'sd0, 16'sd300);
    endtask

    task automatic test_large_sums();
        write_all_settings(16'd0, 16'hFFFF, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
        set_pacing(0, 0);
        repeat (12) send_speeds(16'sh7FFF, 16'sh8000);
        repeat (24) send_speeds(16'sh8000, 16'sh7FFF);
        repeat (12) send_speeds(16'sh7FFF, 16'sh8000);
    endtask

    task automatic test_random_phase(input int idle, input int stall, input bit pause_midway);
        logic signed [15:0] tgt;
        logic signed [15:0] meas;
        bit                 tracking;
        drain_results();
        set_pacing(idle, stall);
        randomize_settings();
        tracking = 1'b0;
        tgt      = 16'sd0;
        meas     = 16'sd0;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (pause_midway && i == PHASE_ITEMS / 2)
                drain_results();
            if (i % 20 == 0)
            begin
                tracking = ($urandom_range(3) != 0);
                tgt      = rand_speed();
                meas     = rand_speed();
            end
            if (tracking)
            begin
                send_speeds(tgt, meas);
                meas = 16'(int'(meas) + (int'(tgt) - int'(meas)) / 2
                           + int'($urandom_range(16)) - 8);
            end
            else
                send_speeds(rand_speed(), rand_speed());
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        target_speed   <= '0;
        measured_speed <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_GAIN_P;
        cfg_data       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_rounding_ties();
        test_windup_threshold();
        test_inverted_limits();
        test_unknown_index();
        test_large_sums();
        test_random_phase(0, 0, 1'b0);
        test_random_phase(48, 0, 1'b1);
        test_random_phase(0, 48, 1'b0);
        test_random_phase(20, 20, 1'b1);

        drain_results();
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
